[design/icd_pkg.sv]
package icd_pkg;

   // Instruction classes: ARM classes first, then Thumb classes
   typedef enum logic [5:0] {
      CL_DP       = 6'd0,
      CL_MUL      = 6'd1,
      CL_HALF     = 6'd2,
      CL_MULL     = 6'd3,
      CL_PSR      = 6'd4,
      CL_SWP      = 6'd5,
      CL_BX       = 6'd6,
      CL_SDT      = 6'd7,
      CL_UND      = 6'd8,
      CL_BDT      = 6'd9,
      CL_B        = 6'd10,
      CL_CDT      = 6'd11,
      CL_CDO      = 6'd12,
      CL_CRT      = 6'd13,
      CL_SWI      = 6'd14,
      TC_LSL      = 6'd15,
      TC_ADDSUB   = 6'd16,
      TC_IMM      = 6'd17,
      TC_ALU      = 6'd18,
      TC_HIREG    = 6'd19,
      TC_PCLD     = 6'd20,
      TC_REGOFS   = 6'd21,
      TC_SIGNEXT  = 6'd22,
      TC_IMMOFS   = 6'd23,
      TC_HALF     = 6'd24,
      TC_SPLS     = 6'd25,
      TC_LDADDR   = 6'd26,
      TC_ADDSP    = 6'd27,
      TC_UND      = 6'd28,
      TC_PUSHPOP  = 6'd29,
      TC_LDMSTM   = 6'd30,
      TC_BCOND    = 6'd31,
      TC_SWI      = 6'd32,
      TC_B        = 6'd33,
      TC_BL       = 6'd34
   } class_type;

   // ARM condition field encoding
   typedef enum logic [3:0] {
      COND_EQ = 4'd0,
      COND_NE = 4'd1,
      COND_CS = 4'd2,
      COND_CC = 4'd3,
      COND_MI = 4'd4,
      COND_PL = 4'd5,
      COND_VS = 4'd6,
      COND_VC = 4'd7,
      COND_HI = 4'd8,
      COND_LS = 4'd9,
      COND_GE = 4'd10,
      COND_LT = 4'd11,
      COND_GT = 4'd12,
      COND_LE = 4'd13,
      COND_AL = 4'd14,
      COND_NV = 4'd15
   } cond_type;

   // Flag positions inside status_flags
   localparam int FLAG_N = 3;
   localparam int FLAG_Z = 2;
   localparam int FLAG_C = 1;
   localparam int FLAG_V = 0;

   // Result of one decode, packed as it leaves on rsp_tdata
   typedef struct packed {
      logic      bad_condition;
      logic      execute;
      class_type instr_class;
   } result_type;

   typedef struct packed {
      logic pass;
      logic bad;
   } cond_result_type;

endpackage

[design/instruction_class_decoder_unit.sv]
// Instruction class decoder unit.
//
// Input stream (req_): one fetched instruction per transfer. req_tdata carries
// the opcode in bits 31..0 and the NZCV flags in bits 35..32; req_tuser is the
// Thumb state bit. Output stream (rsp_): one result per input transfer, in
// order. rsp_tdata carries the class in bits 5..0, execute in bit 6 and the
// invalid-condition flag in bit 7.
//
// Throughput: one instruction per cycle while the receiver does not stall. An
// item is registered on input, run through the ARM, Thumb and condition
// decoders, and lands in the result register, which drives rsp_tvalid and
// rsp_tdata. The decode logic between the two registers sets the cycle
// budget.
//
// Reset clears both valid bits; the payload registers are not reset. When the
// receiver stalls the result register holds, the input register still fills,
// and req_tready drops only once both stages are occupied.
module instruction_class_decoder_unit
   import icd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // opcode[31:0], status_flags[35:32], zero[39:36]
   input  logic        req_tuser,   // thumb_state[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // instr_class[5:0], execute[6], bad_condition[7]
);

   logic            s1_valid_ff, s1_valid_in;
   logic [31:0]     s1_opcode_ff;
   logic            s1_thumb_ff;
   logic [3:0]      s1_flags_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   result_type      rsp_result_ff, rsp_result_in;

   logic            s2_ready;
   logic            req_xfer;
   logic            s1_advance;
   class_type       arm_class;
   class_type       thumb_class;
   cond_result_type cond_res;

   assign s2_ready   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s2_ready;
   assign req_xfer   = req_tvalid && req_tready;
   assign s1_advance = s1_valid_ff && s2_ready;

   icd_arm_decode u_arm (
      .opcode      (s1_opcode_ff),
      .instr_class (arm_class)
   );

   icd_thumb_decode u_thumb (
      .opcode      (s1_opcode_ff[15:0]),
      .instr_class (thumb_class)
   );

   icd_cond_check u_cond (
      .cond         (s1_opcode_ff[31:28]),
      .status_flags (s1_flags_ff),
      .result       (cond_res)
   );

   always_comb begin
      if (s1_thumb_ff) begin
         rsp_result_in.instr_class   = thumb_class;
         rsp_result_in.execute       = 1'b1;
         rsp_result_in.bad_condition = 1'b0;
      end else begin
         rsp_result_in.instr_class   = arm_class;
         rsp_result_in.execute       = cond_res.pass;
         rsp_result_in.bad_condition = cond_res.bad;
      end
   end

   always_comb begin
      s1_valid_in  = req_xfer || (s1_valid_ff && !s2_ready);
      rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_opcode_ff <= req_tdata[31:0];
         s1_flags_ff  <= req_tdata[35:32];
         s1_thumb_ff  <= req_tuser;
      end
      if (s1_advance) begin
         rsp_result_ff <= rsp_result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_result_ff;

   a_bad_no_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7] |-> !rsp_tdata[6])
      else $error("invalid condition result marked as executing");

   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[5:0] <= TC_BL))
      else $error("class code out of range");

   a_thumb_result: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_thumb_ff |=>
         (rsp_tdata[5:0] >= TC_LSL) && rsp_tdata[6] && !rsp_tdata[7])
      else $error("thumb item produced a non-thumb result");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> !(s1_valid_ff && !s2_ready))
      else $error("input stage overwritten while stalled");

endmodule

[design/icd_arm_decode.sv]
module icd_arm_decode
   import icd_pkg::*;
(
   input  logic [31:0] opcode,
   output class_type   instr_class
);

   // Major group from opcode bits 27..25
   localparam logic [2:0] GRP_DP_REG = 3'd0;
   localparam logic [2:0] GRP_DP_IMM = 3'd1;
   localparam logic [2:0] GRP_SDT_IM = 3'd2;
   localparam logic [2:0] GRP_SDT_RG = 3'd3;
   localparam logic [2:0] GRP_BDT    = 3'd4;
   localparam logic [2:0] GRP_BRANCH = 3'd5;
   localparam logic [2:0] GRP_CDT    = 3'd6;
   localparam logic [2:0] GRP_COPROC = 3'd7;

   localparam logic [3:0] LOW_MUL = 4'b1001;
   localparam logic [3:0] LOW_BX  = 4'b0001;
   localparam logic [4:0] MID_BX  = 5'b10010;

   logic [2:0] grp;
   logic [4:0] mid;
   logic [3:0] low;

   assign grp = opcode[27:25];
   assign mid = opcode[24:20];
   assign low = opcode[7:4];

   always_comb begin
      instr_class = CL_DP;
      unique case (grp)
         GRP_DP_REG: begin
            if (mid[4]) begin
               priority if ((mid & 5'b11011) == 5'b10000 && low == LOW_MUL) instr_class = CL_SWP;
               else if (mid == MID_BX && low == LOW_BX)                     instr_class = CL_BX;
               else if (low[3] && low[0])                                   instr_class = CL_HALF;
               else if ((mid & 5'b11001) == 5'b10000)                       instr_class = CL_PSR;
               else                                                         instr_class = CL_DP;
            end else begin
               priority if (mid[4:2] == 3'b000 && low == LOW_MUL)  instr_class = CL_MUL;
               else if (mid[4:3] == 2'b01 && low == LOW_MUL)       instr_class = CL_MULL;
               else if (low[3] && low[0])                          instr_class = CL_HALF;
               else                                                instr_class = CL_DP;
            end
         end
         GRP_DP_IMM: begin
            instr_class = ((mid & 5'b11001) == 5'b10000) ? CL_PSR : CL_DP;
         end
         GRP_SDT_IM: instr_class = CL_SDT;
         GRP_SDT_RG: instr_class = low[0] ? CL_UND : CL_SDT;
         GRP_BDT:    instr_class = CL_BDT;
         GRP_BRANCH: instr_class = CL_B;
         GRP_CDT:    instr_class = CL_CDT;
         GRP_COPROC: begin
            if (mid[4]) instr_class = CL_SWI;
            else        instr_class = low[0] ? CL_CRT : CL_CDO;
         end
         default:    instr_class = CL_DP;
      endcase
   end

endmodule

[design/icd_thumb_decode.sv]
module icd_thumb_decode
   import icd_pkg::*;
(
   input  logic [15:0] opcode,
   output class_type   instr_class
);

   // Format group from opcode bits 15..13
   localparam logic [2:0] GRP_SHIFT  = 3'd0;
   localparam logic [2:0] GRP_IMM    = 3'd1;
   localparam logic [2:0] GRP_REG    = 3'd2;
   localparam logic [2:0] GRP_IMMOFS = 3'd3;
   localparam logic [2:0] GRP_HALFSP = 3'd4;
   localparam logic [2:0] GRP_MISC   = 3'd5;
   localparam logic [2:0] GRP_MULTI  = 3'd6;
   localparam logic [2:0] GRP_BRANCH = 3'd7;

   localparam logic [7:0] HI_SWI = 8'hDF;

   logic [7:0] h;

   assign h = opcode[15:8];

   always_comb begin
      instr_class = TC_UND;
      unique case (h[7:5])
         GRP_SHIFT:  instr_class = (h[4:3] == 2'b11) ? TC_ADDSUB : TC_LSL;
         GRP_IMM:    instr_class = TC_IMM;
         GRP_REG: begin
            priority if (h[4:2] == 3'b000) instr_class = TC_ALU;
            else if (h[4:2] == 3'b001)     instr_class = TC_HIREG;
            else if (h[4:3] == 2'b01)      instr_class = TC_PCLD;
            else if (h[1] && h[4])         instr_class = TC_SIGNEXT;
            else                           instr_class = TC_REGOFS;
         end
         GRP_IMMOFS: instr_class = TC_IMMOFS;
         GRP_HALFSP: instr_class = h[4] ? TC_SPLS : TC_HALF;
         GRP_MISC: begin
            priority if (!h[4])         instr_class = TC_LDADDR;
            else if (h[3:0] == 4'b0000) instr_class = TC_ADDSP;
            else if (h[2:1] == 2'b10)   instr_class = TC_PUSHPOP;
            else                        instr_class = TC_UND;
         end
         GRP_MULTI: begin
            priority if (!h[4])  instr_class = TC_LDMSTM;
            else if (h == HI_SWI) instr_class = TC_SWI;
            else                 instr_class = TC_BCOND;
         end
         GRP_BRANCH: begin
            priority if (h[4:3] == 2'b00) instr_class = TC_B;
            else if (h[4])                instr_class = TC_BL;
            else                          instr_class = TC_UND;
         end
         default:    instr_class = TC_UND;
      endcase
   end

endmodule

[design/icd_cond_check.sv]
module icd_cond_check
   import icd_pkg::*;
(
   input  logic [3:0]      cond,
   input  logic [3:0]      status_flags,
   output cond_result_type result
);

   logic n, z, c, v;

   assign n = status_flags[FLAG_N];
   assign z = status_flags[FLAG_Z];
   assign c = status_flags[FLAG_C];
   assign v = status_flags[FLAG_V];

   always_comb begin
      result.bad  = (cond_type'(cond) == COND_NV);
      result.pass = 1'b0;
      unique case (cond_type'(cond))
         COND_EQ: result.pass = z;
         COND_NE: result.pass = !z;
         COND_CS: result.pass = c;
         COND_CC: result.pass = !c;
         COND_MI: result.pass = n;
         COND_PL: result.pass = !n;
         COND_VS: result.pass = v;
         COND_VC: result.pass = !v;
         COND_HI: result.pass = c && !z;
         COND_LS: result.pass = !c || z;
         COND_GE: result.pass = (n == v);
         COND_LT: result.pass = (n != v);
         COND_GT: result.pass = !z && (n == v);
         COND_LE: result.pass = z || (n != v);
         COND_AL: result.pass = 1'b1;
         COND_NV: result.pass = 1'b0;
         default: result.pass = 1'b0;
      endcase
   end

endmodule
